// File: rtl/core/stlm_pkg.sv
package stlm_pkg;

    // Address space and access limits.
    localparam int ADDR_BITS        = 16;
    localparam int MAX_ACCESS_BYTES = 64;
    localparam int SIZE_W           = 7;
    localparam int COUNT_W          = 32;

    // A tag holds an access size, so it is as wide as the size field.
    localparam int TAG_W = SIZE_W;

    // One memory row holds the tags of one aligned line. The line is the
    // smallest power of two that holds the largest access, so an aligned
    // access never crosses a row.
    localparam int OFF_BITS   = $clog2(MAX_ACCESS_BYTES);
    localparam int LINE_BYTES = 1 << OFF_BITS;
    localparam int LINE_BITS  = ADDR_BITS - OFF_BITS;
    localparam int LINE_DEPTH = 1 << LINE_BITS;
    localparam int LINE_W     = LINE_BYTES * TAG_W;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((ADDR_BITS + SIZE_W + 7) / 8) * 8;
    localparam int M_FIELDS = 1 + 2 * COUNT_W;
    localparam int M_DATA_W = ((M_FIELDS + 7) / 8) * 8;

    // Request kinds carried on s_tuser.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Outcome of one access against its tag row.
    typedef struct packed {
        logic matched;
        logic wr_en;
    } stlm_status_t;

endpackage

// File: rtl/core/stlm_ram.sv
module stlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same row is written in the same cycle.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/stlm_line_unit.sv
module stlm_line_unit
    import stlm_pkg::*;
(
    input  logic [LINE_W-1:0]   line_in,
    input  logic [OFF_BITS-1:0] offset,
    input  logic [SIZE_W-1:0]   size,
    input  logic                is_write,
    output logic [LINE_W-1:0]   line_out,
    output stlm_status_t        status
);

    localparam int SUM_W = SIZE_W + 2;

    logic [SUM_W-1:0] lo;
    logic [SUM_W-1:0] hi;
    logic             oversize;
    logic             all_equal;
    logic [LINE_BYTES-1:0] covered;

    assign lo       = SUM_W'(offset);
    assign hi       = SUM_W'(offset) + SUM_W'(size);
    assign oversize = (SUM_W'(size) > SUM_W'(MAX_ACCESS_BYTES));

    // Each byte lane checks and rewrites its own tag.
    always_comb begin
        all_equal = 1'b1;
        line_out  = line_in;
        for (int j = 0; j < LINE_BYTES; j++) begin
            covered[j] = (SUM_W'(j) >= lo) && (SUM_W'(j) < hi);
            if (covered[j] && (line_in[j*TAG_W +: TAG_W] != size)) begin
                all_equal = 1'b0;
            end
            if (covered[j]) begin
                line_out[j*TAG_W +: TAG_W] = size;
            end
        end
    end

    // A zero size covers nothing: a read matches, a write changes nothing.
    assign status.matched = !oversize && all_equal;
    assign status.wr_en   = is_write && !oversize && (size != '0);

endmodule

// File: rtl/core/store_load_size_match_tracker.sv
// Channel  Dir  Payload (lowest bit first)                         Handshake
// s_       in   tdata: byte_address, access_size; tuser: req_type  s_tvalid/s_tready
// m_       out  tdata: size_matched, match_total, mismatch_total;  m_tvalid/m_tready
//               tuser: was_read
//
// One transaction is taken per cycle when the result side keeps up. The tag
// memory holds one row of byte tags per aligned line; a transaction's row is
// read at its accepting edge and written back when the execute stage fires,
// which also loads its result into the output register.
// After reset a clearing pass zeroes the tag memory, one row a cycle, over all
// LINE_DEPTH (1024) rows; s_tready stays low during that pass.
// A stalled result holds the execute stage, which in turn holds s_tready low.
module store_load_size_match_tracker
    import stlm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // byte_address, access_size, zero pad
    input  logic [0:0]          s_tuser,   // req_type

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // size_matched, match_total, mismatch_total, pad
    output logic [0:0]          m_tuser    // was_read
);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // Control state.
    logic                 st_reg, st_next;
    logic [LINE_BITS-1:0] clr_idx_reg;
    logic                 ex_valid_reg;
    logic                 ex_fwd_reg;
    logic                 m_valid_reg;
    logic [COUNT_W-1:0]   match_cnt_reg, match_cnt_next;
    logic [COUNT_W-1:0]   mismatch_cnt_reg, mismatch_cnt_next;

    // Payload held by the execute stage and the output register.
    logic                 ex_write_reg;
    logic [LINE_BITS-1:0] ex_line_reg;
    logic [OFF_BITS-1:0]  ex_off_reg;
    logic [SIZE_W-1:0]    ex_size_reg;
    logic [LINE_W-1:0]    fwd_data_reg;
    logic [M_DATA_W-1:0]  m_data_reg;
    logic                 m_user_reg;

    // Input decode and address alignment.
    logic                 s_accept;
    logic                 in_write;
    logic [ADDR_BITS-1:0] in_addr;
    logic [SIZE_W-1:0]    in_size;
    logic [ADDR_BITS-1:0] align_mask;
    logic [ADDR_BITS-1:0] aligned;
    logic [LINE_BITS-1:0] in_line;

    assign in_write = (s_tuser[0] == REQ_WRITE);
    assign in_addr  = s_tdata[ADDR_BITS-1:0];
    assign in_size  = s_tdata[ADDR_BITS +: SIZE_W];

    // Size minus one, where a zero size wraps to all ones and clears every bit.
    assign align_mask = (in_size == '0) ? '1 : ADDR_BITS'(in_size - 1'b1);
    assign aligned    = in_addr & ~align_mask;
    assign in_line    = aligned[ADDR_BITS-1:OFF_BITS];

    // Execute stage: merge the row, decide the outcome, write back.
    logic [LINE_W-1:0]    ram_rdata;
    logic [LINE_W-1:0]    cur_line;
    logic [LINE_W-1:0]    new_line;
    stlm_status_t         status;
    logic                 ex_fire;
    logic                 ex_wr;

    // A row written back in the same cycle as the next read is taken from
    // the forwarding register instead of the memory's stale output.
    assign cur_line = ex_fwd_reg ? fwd_data_reg : ram_rdata;

    stlm_line_unit u_line (
        .line_in  (cur_line),
        .offset   (ex_off_reg),
        .size     (ex_size_reg),
        .is_write (ex_write_reg),
        .line_out (new_line),
        .status   (status)
    );

    assign ex_fire  = ex_valid_reg && (!m_valid_reg || m_tready);
    assign ex_wr    = ex_fire && status.wr_en;
    assign s_tready = (st_reg == ST_RUN) && (!ex_valid_reg || ex_fire);
    assign s_accept = s_tvalid && s_tready;

    // Tag memory: the clearing pass owns the write port until it finishes.
    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_waddr;
    logic [LINE_W-1:0]    ram_wdata;

    always_comb begin
        if (st_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = ex_wr;
            ram_waddr = ex_line_reg;
            ram_wdata = new_line;
        end
    end

    stlm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_tags (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_line),
        .rdata (ram_rdata)
    );

    // Saturating counters; only reads count.
    always_comb begin
        match_cnt_next    = match_cnt_reg;
        mismatch_cnt_next = mismatch_cnt_reg;
        if (ex_fire && !ex_write_reg) begin
            if (status.matched) begin
                if (match_cnt_reg != '1) begin
                    match_cnt_next = match_cnt_reg + 1'b1;
                end
            end else begin
                if (mismatch_cnt_reg != '1) begin
                    mismatch_cnt_next = mismatch_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        if ((st_reg == ST_CLEAR) && (clr_idx_reg == '1)) begin
            st_next = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg           <= ST_CLEAR;
            clr_idx_reg      <= '0;
            ex_valid_reg     <= 1'b0;
            ex_fwd_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            match_cnt_reg    <= '0;
            mismatch_cnt_reg <= '0;
        end else begin
            st_reg           <= st_next;
            match_cnt_reg    <= match_cnt_next;
            mismatch_cnt_reg <= mismatch_cnt_next;
            if (st_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (s_accept) begin
                ex_valid_reg <= 1'b1;
                ex_fwd_reg   <= ex_wr && (ex_line_reg == in_line);
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
                ex_fwd_reg   <= 1'b0;
            end
            if (ex_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_write_reg <= in_write;
            ex_line_reg  <= in_line;
            ex_off_reg   <= aligned[OFF_BITS-1:0];
            ex_size_reg  <= in_size;
            fwd_data_reg <= new_line;
        end
        if (ex_fire) begin
            m_user_reg <= !ex_write_reg;
            m_data_reg <= M_DATA_W'({mismatch_cnt_next, match_cnt_next,
                                     (!ex_write_reg && status.matched)});
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // No transaction is taken while the tag memory is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during tag clearing");

    // A single transaction never moves both counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !((match_cnt_reg != $past(match_cnt_reg)) &&
          (mismatch_cnt_reg != $past(mismatch_cnt_reg))))
        else $error("both counters changed in one cycle");

    // Forwarding is only armed for a transaction held in the execute stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ex_fwd_reg |-> ex_valid_reg)
        else $error("forwarding armed without a pending transaction");

    // The match counter never runs backward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (match_cnt_reg >= $past(match_cnt_reg)))
        else $error("match counter decreased");

endmodule

// File: tb/sv/store_load_size_match_tracker_tb.sv
module store_load_size_match_tracker_tb;
    import stlm_pkg::*;

    // The run cannot get near the 32-bit counter ceiling, so the saturation
    // branch of the predictor is carried but never reached.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD_OFF = 300;

    // One expected result, with the fields in the order the result port uses.
    typedef struct packed {
        logic               was_read;
        logic               size_matched;
        logic [COUNT_W-1:0] match_total;
        logic [COUNT_W-1:0] mismatch_total;
    } access_outcome_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;    // byte_address, access_size, zero pad
    logic [0:0]          s_tuser = '0;    // req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // size_matched, match_total, mismatch_total, pad
    logic [0:0]          m_tuser;         // was_read

    // Shadow of the tracker: one size tag per byte plus the two read counters.
    logic [TAG_W-1:0]   size_tags [0:(1 << ADDR_BITS)-1];
    logic [COUNT_W-1:0] matched_reads;
    logic [COUNT_W-1:0] mismatched_reads;

    access_outcome_t expected_outcomes[$];
    access_outcome_t oldest_outcome;

    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;
    int output_hold_cycles = 0;
    int error_count        = 0;
    int items_accepted     = 0;
    int reads_accepted     = 0;
    int cycle_count        = 0;

    store_load_size_match_tracker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Works out the result of one accepted access and updates the shadow.
    // The address is aligned down by clearing the bits of size minus one; a
    // zero size therefore clears every bit and covers no byte at all.
    function automatic access_outcome_t predict_access(input logic req,
                                                       input logic [ADDR_BITS-1:0] addr,
                                                       input logic [SIZE_W-1:0] size);
        logic [ADDR_BITS-1:0] span_mask;
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] idx;
        logic                 oversize;
        logic                 all_equal;
        access_outcome_t      outcome;
        span_mask = ADDR_BITS'(size) - ADDR_BITS'(1);
        base      = addr & ~span_mask;
        oversize  = (int'(size) > MAX_ACCESS_BYTES);
        all_equal = 1'b0;
        if (req == REQ_WRITE) begin
            // An oversize write is refused and leaves every tag alone.
            if (!oversize) begin
                for (int i = 0; i < int'(size); i++) begin
                    idx = base + ADDR_BITS'(i);
                    size_tags[idx] = size;
                end
            end
        end else begin
            // An oversize read always counts as a mismatch. Covered byte
            // addresses wrap at the top of the address space.
            if (!oversize) begin
                all_equal = 1'b1;
                for (int i = 0; i < int'(size); i++) begin
                    idx = base + ADDR_BITS'(i);
                    if (size_tags[idx] != size) begin
                        all_equal = 1'b0;
                    end
                end
            end
            if (all_equal) begin
                if (matched_reads != '1) begin
                    matched_reads = matched_reads + 1'b1;
                end
            end else if (mismatched_reads != '1) begin
                mismatched_reads = mismatched_reads + 1'b1;
            end
        end
        outcome.was_read       = (req == REQ_READ);
        outcome.size_matched   = (req == REQ_READ) && all_equal;
        outcome.match_total    = matched_reads;
        outcome.mismatch_total = mismatched_reads;
        return outcome;
    endfunction

    // Offers one access, after a random gap when the sender is idling, and
    // records its expected result at the edge where the transaction happens.
    task automatic send_access(input logic req, input logic [ADDR_BITS-1:0] addr,
                               input logic [SIZE_W-1:0] size);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_DATA_W - ADDR_BITS - SIZE_W){1'b0}}, size, addr};
        do @(posedge aclk); while (!s_tready);
        expected_outcomes.push_back(predict_access(req, addr, size));
        items_accepted++;
        if (req == REQ_READ) begin
            reads_accepted++;
        end
    endtask

    // Blocks until every expected result has come back.
    task automatic wait_for_drain();
        while (expected_outcomes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [SIZE_W-1:0] power_of_two_size();
        return SIZE_W'(1 << $urandom_range(0, OFF_BITS));
    endfunction

    // Most addresses fall in a handful of lines, so that reads find the tags
    // that earlier writes left behind. The first and last lines are included
    // to reach the edges of the address space.
    function automatic logic [ADDR_BITS-1:0] pooled_address();
        logic [LINE_BITS-1:0] line;
        case ($urandom_range(0, 7))
            0: begin
                line = '0;
            end
            1: begin
                line = '1;
            end
            2: begin
                line = LINE_BITS'(16'h5555);
            end
            3: begin
                line = LINE_BITS'(16'hAAAA);
            end
            4: begin
                line = LINE_BITS'(1);
            end
            5: begin
                line = LINE_BITS'(1 << (LINE_BITS - 1));
            end
            default: begin
                line = LINE_BITS'($urandom);
            end
        endcase
        return {line, OFF_BITS'($urandom)};
    endfunction

    task automatic test_directed_corners();
        // Reset memory holds zero tags, so a one-byte read cannot match.
        send_access(REQ_READ,  16'h0000, 7'd1);
        // A zero size covers nothing: the read matches and the write is a no-op.
        send_access(REQ_READ,  16'hFFFF, 7'd0);
        send_access(REQ_WRITE, 16'h1234, 7'd0);
        send_access(REQ_READ,  16'h1234, 7'd1);
        // Widest access on the last line of the address space.
        send_access(REQ_WRITE, 16'hFFFF, 7'd64);
        send_access(REQ_READ,  16'hFFC5, 7'd64);
        send_access(REQ_READ,  16'hFFFF, 7'd1);
        send_access(REQ_WRITE, 16'hFFFF, 7'd1);
        send_access(REQ_READ,  16'hFFC0, 7'd64);
        send_access(REQ_READ,  16'hFFFF, 7'd1);
        // Oversize accesses are refused; the largest field value among them.
        send_access(REQ_WRITE, 16'h0100, 7'd127);
        send_access(REQ_READ,  16'h0100, 7'd127);
        send_access(REQ_WRITE, 16'h0140, 7'd65);
        send_access(REQ_READ,  16'h0140, 7'd65);
        // Sizes that are not a power of two align by the same bit clearing.
        send_access(REQ_WRITE, 16'h0043, 7'd3);
        send_access(REQ_READ,  16'h0041, 7'd3);
        send_access(REQ_READ,  16'h0043, 7'd3);
        send_access(REQ_WRITE, 16'h7FFF, 7'd63);
        send_access(REQ_READ,  16'h7FC1, 7'd63);
        // Power-of-two sizes, aligned down from their addresses, read back with the same and other sizes.
        send_access(REQ_WRITE, 16'h8001, 7'd2);
        send_access(REQ_READ,  16'h8000, 7'd2);
        send_access(REQ_READ,  16'h8000, 7'd4);
        send_access(REQ_WRITE, 16'hAAAA, 7'd32);
        send_access(REQ_READ,  16'hAAA0, 7'd16);
        send_access(REQ_READ,  16'hAABF, 7'd32);
        s_tvalid <= 1'b0;
    endtask

    // Mostly write-then-read pairs with random content, plus reads of other
    // sizes, the zero and oversize special cases and fully random noise.
    task automatic test_random_mix(input int item_count);
        int                   sent;
        int                   pick;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_W-1:0]    size;
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(0, 99);
            addr = pooled_address();
            if (pick < 50) begin
                size = power_of_two_size();
                send_access(REQ_WRITE, addr, size);
                send_access(REQ_READ, addr ^ ADDR_BITS'($urandom_range(0, int'(size) - 1)), size);
                sent += 2;
            end else if (pick < 65) begin
                send_access(REQ_READ, addr, power_of_two_size());
                sent++;
            end else if (pick < 75) begin
                send_access(REQ_WRITE, addr, power_of_two_size());
                sent++;
            end else if (pick < 84) begin
                size = SIZE_W'($urandom_range(1, MAX_ACCESS_BYTES));
                send_access(REQ_WRITE, addr, size);
                send_access(REQ_READ, addr, size);
                sent += 2;
            end else if (pick < 88) begin
                send_access(logic'($urandom_range(0, 1)), addr, 7'd0);
                sent++;
            end else if (pick < 93) begin
                size = SIZE_W'($urandom_range(MAX_ACCESS_BYTES + 1, (1 << SIZE_W) - 1));
                send_access(logic'($urandom_range(0, 1)), addr, size);
                sent++;
            end else begin
                send_access(logic'($urandom_range(0, 1)), ADDR_BITS'($urandom),
                            SIZE_W'($urandom));
                sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // The result side holds off for a long stretch while the sender keeps
    // offering back-to-back transactions, so the block fills and stalls its
    // input. Then the sender pauses until every result is back, and sends more.
    task automatic test_output_stall_fill();
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_W-1:0]    size;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        output_hold_cycles = LONG_HOLD_OFF;
        for (int i = 0; i < 20; i++) begin
            addr = pooled_address();
            size = power_of_two_size();
            send_access(REQ_WRITE, addr, size);
            send_access(REQ_READ, addr, size);
        end
        s_tvalid <= 1'b0;
        wait_for_drain();
        for (int i = 0; i < 30; i++) begin
            send_access(logic'($urandom_range(0, 1)), pooled_address(), power_of_two_size());
        end
        s_tvalid <= 1'b0;
    endtask

    // Result side: a long hold-off when one is requested, otherwise random
    // stalls at the rate of the current idle mix.
    always @(posedge aclk) begin
        if (output_hold_cycles > 0) begin
            m_tready <= 1'b0;
            output_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every result transaction is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result transaction arrived with no access outstanding");
                error_count++;
            end else begin
                oldest_outcome = expected_outcomes.pop_front();
                if (m_tuser[0] !== oldest_outcome.was_read) begin
                    $error("was_read: expected %0d, got %0d", oldest_outcome.was_read,
                           m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[0] !== oldest_outcome.size_matched) begin
                    $error("size_matched: expected %0d, got %0d", oldest_outcome.size_matched,
                           m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[COUNT_W:1] !== oldest_outcome.match_total) begin
                    $error("match_total: expected %0d, got %0d", oldest_outcome.match_total,
                           m_tdata[COUNT_W:1]);
                    error_count++;
                end
                if (m_tdata[2*COUNT_W:COUNT_W+1] !== oldest_outcome.mismatch_total) begin
                    $error("mismatch_total: expected %0d, got %0d",
                           oldest_outcome.mismatch_total, m_tdata[2*COUNT_W:COUNT_W+1]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog; the limit also covers the clearing pass after reset.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < (1 << ADDR_BITS); i++) begin
            size_tags[i] = '0;
        end
        matched_reads    = '0;
        mismatched_reads = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();

        // Four idle mixes: none, sender only, receiver only, both.
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_mix(210);
        send_idle_pct = 49; recv_stall_pct = 0;
        test_random_mix(210);
        send_idle_pct = 0;  recv_stall_pct = 49;
        test_random_mix(210);
        send_idle_pct = 36; recv_stall_pct = 36;
        test_random_mix(210);

        test_output_stall_fill();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d accesses, %0d of them reads (%0d matched, %0d mismatched),",
                 items_accepted, reads_accepted, matched_reads, mismatched_reads);
        $display("under four idle mixes and one long result-side hold-off.");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/stlm_pkg.sv
rtl/core/stlm_ram.sv
rtl/core/stlm_line_unit.sv
rtl/core/store_load_size_match_tracker.sv
tb/sv/store_load_size_match_tracker_tb.sv
